// File: hdl/gco_pkg.sv
package gco_pkg;

    localparam int CORDIC_STEPS_DEF = 32;
    localparam int TOTAL_WIDTH_DEF  = 48;

    // Datapath width: Q2.30 values plus headroom for the CORDIC gain.
    localparam int DW   = 36;
    localparam int PW   = 2 * DW;
    localparam int FRAC = 30;
    localparam int TW_T = 56;

    localparam logic signed [DW-1:0] HALF_PI_Q = 36'sd1686629713;
    localparam logic signed [DW-1:0] GAIN_Q    = 36'sd652032874;
    localparam logic signed [DW-1:0] MM_SCALE  = 36'sd1000;
    localparam logic signed [PW-1:0] ROUND_HALF = 72'sd536870912;

    localparam logic [21:0] DEG_DIV  = 22'd3515625;
    localparam logic [21:0] DEG_HALF = 22'd1757812;

    // floor(2^53 / DEG_DIV): the estimate never exceeds the true quotient
    // and falls short of it by at most one.
    localparam logic signed [DW-1:0] DEG_RCP   = 36'sd2562047788;
    localparam logic signed [PW-1:0] RCP_HALF  = 72'sd1073741824;
    localparam int                   RCP_SHIFT = 31;

    localparam logic [5:0]  MIN_SAT_RST = 6'd4;
    localparam logic [22:0] RADIUS_RST  = 23'd6372795;

    localparam logic REG_MIN_SAT = 1'b0;
    localparam logic REG_RADIUS  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_DIV_Q,
        ST_DIV_CHK,
        ST_DIV_END,
        ST_SC_MUL,
        ST_SC_INIT,
        ST_CORDIC,
        ST_SC_END,
        ST_MUL,
        ST_MACC,
        ST_VEC1_END,
        ST_ATAN_SETUP,
        ST_ATAN_END,
        ST_ACC
    } t_state;

    typedef enum logic [3:0] {
        MOP_SCALE,
        MOP_A,
        MOP_B1,
        MOP_B2,
        MOP_B3,
        MOP_D1,
        MOP_D2,
        MOP_D3,
        MOP_NUM,
        MOP_T,
        MOP_HI,
        MOP_LO,
        MOP_RCP,
        MOP_BACK
    } t_mop;

    typedef enum logic [1:0] {
        JOB_SINCOS,
        JOB_MAG,
        JOB_ATAN
    } t_job;

    // Arctangent of 2^-i in Q2.30; beyond the table atan(x) rounds to x.
    function automatic logic signed [DW-1:0] f_atan(input logic [5:0] i);
        logic signed [DW-1:0] r;
        logic [5:0]           sh;
        r  = '0;
        sh = 6'd30 - i;
        case (i)
            6'd0:  r = 36'sd843314857;
            6'd1:  r = 36'sd497837829;
            6'd2:  r = 36'sd263043837;
            6'd3:  r = 36'sd133525159;
            6'd4:  r = 36'sd67021687;
            6'd5:  r = 36'sd33543516;
            6'd6:  r = 36'sd16775851;
            6'd7:  r = 36'sd8388437;
            6'd8:  r = 36'sd4194283;
            6'd9:  r = 36'sd2097149;
            6'd10: r = 36'sd1048576;
            default: begin
                if (i <= 6'd30) begin
                    r = 36'sd1 <<< sh;
                end
            end
        endcase
        return r;
    endfunction

endpackage

// File: hdl/gps_great_circle_odometer.sv
// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_ready      fix_valid, satellite_count, lat, lon
// output    out        o_out_valid / i_out_ready    total_distance_mm, flags
// config    in         psel, penable, pwrite        paddr, pwdata, prdata
//
// A rejected fix gives its result in the cycle after acceptance.
// The first accepted fix gives its result after two conversions to binary angle on the shared
// multiplier, each through ST_DIV, ST_DIV_Q, ST_DIV_CHK and ST_DIV_END.
// Later fixes are timed by the shared CORDIC stage (five passes) and the shared multiplier;
// a zero atan2 vector skips the arctangent pass.
// Reset is synchronous and clears the stored fix and the total.
// A pending result stalls input; the next request is taken as the result leaves.
module gps_great_circle_odometer import gco_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int TOTAL_WIDTH  = TOTAL_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_fix_valid,
    input  logic [5:0]          i_satellite_count,
    input  logic signed [30:0]  i_latitude_e7,
    input  logic signed [31:0]  i_longitude_e7,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [47:0]         o_total_distance_mm,
    output logic                o_fix_accepted,
    output logic                o_distance_added,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int IW = $clog2(CORDIC_STEPS);
    localparam int SW = ((TOTAL_WIDTH > DW) ? TOTAL_WIDTH : DW) + 1;
    localparam logic [TOTAL_WIDTH-1:0] MAXV = {TOTAL_WIDTH{1'b1}};

    t_state r_state, n_state;

    logic                    r_out_valid;
    logic                    r_acc_flag;
    logic                    r_add_flag;
    logic                    r_have;
    logic [TOTAL_WIDTH-1:0]  r_total;
    logic [5:0]              r_min_sat;
    logic [22:0]             r_radius;

    logic [31:0]             r_last_lat;
    logic [31:0]             r_last_lon;
    logic [31:0]             r_nlat;
    logic signed [31:0]      r_lon_in;

    logic [31:0]             r_mag;
    logic [31:0]             r_dq;
    logic                    r_neg;
    logic                    r_div_lon;

    logic signed [DW-1:0]    r_x, r_y, r_z;
    logic [IW-1:0]           r_i;
    logic                    r_vec;
    t_job                    r_job;
    logic [1:0]              r_quad;
    logic [1:0]              r_k;

    logic signed [DW-1:0]    r_s1, r_c1, r_s2, r_c2, r_sd, r_cd;
    logic signed [DW-1:0]    r_a, r_b, r_tmp, r_den, r_num, r_off, r_ang;
    logic [TW_T-1:0]         r_t;
    logic [DW-1:0]           r_seg;

    t_mop                    r_op;
    logic signed [PW-1:0]    r_prod;

    logic in_acc, out_acc, cfg_wr, fix_ok;
    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = r_out_valid && i_out_ready;
    assign cfg_wr  = psel && penable && pwrite;
    assign fix_ok  = i_fix_valid && (i_satellite_count >= r_min_sat);

    assign o_in_ready          = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign o_out_valid         = r_out_valid;
    assign o_fix_accepted      = r_acc_flag;
    assign o_distance_added    = r_add_flag;
    assign pready              = 1'b1;

    logic [63:0] total_ext;
    assign total_ext           = 64'(r_total);
    assign o_total_distance_mm = total_ext[47:0];
    assign prdata = (paddr[2] == REG_RADIUS) ? {9'd0, r_radius} : {26'd0, r_min_sat};

    // Degrees to binary angle: a reciprocal estimate on the shared multiplier,
    // then one back-multiply and a compare that adds the missing unit if any.
    logic signed [PW-1:0] div_rnd;
    logic [31:0]          div_qe;
    logic [55:0]          div_num, div_rem;
    logic                 div_ge;
    logic [31:0]          div_q, div_ang;
    always_comb begin
        div_rnd = (r_prod + RCP_HALF) >>> RCP_SHIFT;
        div_qe  = div_rnd[31:0];
        div_num = {2'd0, r_mag, DEG_HALF};
        div_rem = div_num - r_prod[55:0];
        div_ge  = div_rem >= {34'd0, DEG_DIV};
        div_q   = r_dq + {31'd0, div_ge};
        div_ang = r_neg ? (32'd0 - div_q) : div_q;
    end

    logic [31:0] lat_mag, lon_mag;
    logic signed [31:0] lat_ext;
    assign lat_ext = 32'(i_latitude_e7);
    assign lat_mag = lat_ext[31] ? (32'd0 - lat_ext) : lat_ext;
    assign lon_mag = r_lon_in[31] ? (32'd0 - r_lon_in) : r_lon_in;

    // Shared CORDIC stage.
    logic signed [DW-1:0] c_dx, c_dy, c_at, c_nx, c_ny, c_nz;
    logic                 c_sub;
    logic                 c_last;
    always_comb begin
        c_dx  = r_y >>> r_i;
        c_dy  = r_x >>> r_i;
        c_at  = f_atan(6'(r_i));
        c_sub = r_vec ? r_y[DW-1] : !r_z[DW-1];
        if (c_sub) begin
            c_nx = r_x - c_dx;
            c_ny = r_y + c_dy;
            c_nz = r_z - c_at;
        end else begin
            c_nx = r_x + c_dx;
            c_ny = r_y - c_dy;
            c_nz = r_z + c_at;
        end
        c_last = (r_i == IW'(CORDIC_STEPS - 1));
    end

    // Angle for the current sine/cosine job.
    logic [31:0] sc_ang;
    always_comb begin
        case (r_k)
            2'd0:    sc_ang = r_last_lat;
            2'd1:    sc_ang = r_nlat;
            default: sc_ang = r_lon_in - r_last_lon;
        endcase
    end
    // r_lon_in holds the new binary longitude once both conversions are done.

    // Shared multiplier with operand selection.
    t_mop                 mop;
    logic signed [DW-1:0] m_a, m_b;
    logic signed [PW-1:0] m_p;
    logic signed [PW-1:0] rq_full;
    logic signed [DW-1:0] rq;
    always_comb begin
        case (r_state)
            ST_SC_MUL:  mop = MOP_SCALE;
            ST_DIV:     mop = MOP_RCP;
            ST_DIV_CHK: mop = MOP_BACK;
            default:    mop = r_op;
        endcase
        case (mop)
            MOP_SCALE: begin m_a = {6'd0, sc_ang[29:0]}; m_b = HALF_PI_Q; end
            MOP_A:     begin m_a = r_c2;  m_b = r_sd; end
            MOP_B1:    begin m_a = r_c1;  m_b = r_s2; end
            MOP_B2:    begin m_a = r_s1;  m_b = r_c2; end
            MOP_B3:    begin m_a = r_tmp; m_b = r_cd; end
            MOP_D1:    begin m_a = r_s1;  m_b = r_s2; end
            MOP_D2:    begin m_a = r_c1;  m_b = r_c2; end
            MOP_D3:    begin m_a = r_tmp; m_b = r_cd; end
            MOP_NUM:   begin m_a = r_x;   m_b = GAIN_Q; end
            MOP_T:     begin m_a = {13'd0, r_radius}; m_b = r_ang; end
            MOP_HI:    begin m_a = {10'd0, r_t[TW_T-1:FRAC]}; m_b = MM_SCALE; end
            MOP_LO:    begin m_a = {6'd0, r_t[FRAC-1:0]}; m_b = MM_SCALE; end
            MOP_RCP:   begin m_a = {4'd0, r_mag}; m_b = DEG_RCP; end
            MOP_BACK:  begin m_a = {4'd0, r_dq};  m_b = {14'd0, DEG_DIV}; end
            default:   begin m_a = '0; m_b = '0; end
        endcase
        m_p     = m_a * m_b;
        rq_full = (r_prod + ROUND_HALF) >>> FRAC;
        rq      = rq_full[DW-1:0];
    end

    logic signed [DW-1:0] neg_a, abs_a;
    assign neg_a = -r_a;
    assign abs_a = r_a[DW-1] ? neg_a : r_a;

    logic signed [DW-1:0] ang_sum;
    assign ang_sum = r_z + r_off;

    logic [SW-1:0] sat_sum;
    assign sat_sum = SW'(r_total) + SW'(r_seg);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:       if (in_acc && fix_ok) n_state = ST_DIV;
            ST_DIV:        n_state = ST_DIV_Q;
            ST_DIV_Q:      n_state = ST_DIV_CHK;
            ST_DIV_CHK:    n_state = ST_DIV_END;
            ST_DIV_END: begin
                if (!r_div_lon) begin
                    n_state = ST_DIV;
                end else if (r_have) begin
                    n_state = ST_SC_MUL;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SC_MUL:     n_state = ST_SC_INIT;
            ST_SC_INIT:    n_state = ST_CORDIC;
            ST_CORDIC: begin
                if (c_last) begin
                    case (r_job)
                        JOB_SINCOS: n_state = ST_SC_END;
                        JOB_MAG:    n_state = ST_VEC1_END;
                        default:    n_state = ST_ATAN_END;
                    endcase
                end
            end
            ST_SC_END:     n_state = (r_k == 2'd2) ? ST_MUL : ST_SC_MUL;
            ST_MUL:        n_state = ST_MACC;
            ST_MACC: begin
                case (r_op)
                    MOP_D3:  n_state = ST_CORDIC;
                    MOP_NUM: n_state = ST_ATAN_SETUP;
                    MOP_LO:  n_state = ST_ACC;
                    default: n_state = ST_MUL;
                endcase
            end
            ST_VEC1_END:   n_state = ST_MUL;
            ST_ATAN_SETUP: n_state = (r_num == '0 && r_den == '0) ? ST_MUL : ST_CORDIC;
            ST_ATAN_END:   n_state = ST_MUL;
            ST_ACC:        n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control state, totals and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_acc_flag  <= 1'b0;
            r_add_flag  <= 1'b0;
            r_have      <= 1'b0;
            r_total     <= '0;
            r_min_sat   <= MIN_SAT_RST;
            r_radius    <= RADIUS_RST;
        end else begin
            if (out_acc) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_wr) begin
                if (paddr[2] == REG_RADIUS) begin
                    r_radius <= pwdata[22:0];
                end else begin
                    r_min_sat <= pwdata[5:0];
                end
            end
            if (in_acc && !fix_ok) begin
                r_out_valid <= 1'b1;
                r_acc_flag  <= 1'b0;
                r_add_flag  <= 1'b0;
            end
            if (r_state == ST_DIV_END && r_div_lon && !r_have) begin
                r_have      <= 1'b1;
                r_out_valid <= 1'b1;
                r_acc_flag  <= 1'b1;
                r_add_flag  <= 1'b0;
            end
            if (r_state == ST_ACC) begin
                r_total     <= (sat_sum > SW'(MAXV)) ? MAXV : sat_sum[TOTAL_WIDTH-1:0];
                r_out_valid <= 1'b1;
                r_acc_flag  <= 1'b1;
                r_add_flag  <= 1'b1;
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_lon_in  <= i_longitude_e7;
                    r_mag     <= lat_mag;
                    r_neg     <= lat_ext[31];
                    r_div_lon <= 1'b0;
                end
            end
            ST_DIV: begin
                r_prod <= m_p;
            end
            ST_DIV_Q: begin
                r_dq <= div_qe;
            end
            ST_DIV_CHK: begin
                r_prod <= m_p;
            end
            ST_DIV_END: begin
                if (!r_div_lon) begin
                    r_nlat    <= div_ang;
                    r_mag     <= lon_mag;
                    r_neg     <= r_lon_in[31];
                    r_div_lon <= 1'b1;
                end else begin
                    r_lon_in <= div_ang;
                    r_k      <= 2'd0;
                    if (!r_have) begin
                        r_last_lat <= r_nlat;
                        r_last_lon <= div_ang;
                    end
                end
            end
            ST_SC_MUL: begin
                r_prod <= m_p;
                r_quad <= sc_ang[31:30];
            end
            ST_SC_INIT: begin
                r_x   <= GAIN_Q;
                r_y   <= '0;
                r_z   <= rq;
                r_i   <= '0;
                r_vec <= 1'b0;
                r_job <= JOB_SINCOS;
            end
            ST_CORDIC: begin
                r_x <= c_nx;
                r_y <= c_ny;
                r_z <= c_nz;
                r_i <= r_i + IW'(1);
            end
            ST_SC_END: begin
                logic signed [DW-1:0] s, c;
                case (r_quad)
                    2'd0:    begin c = r_x;  s = r_y;  end
                    2'd1:    begin c = -r_y; s = r_x;  end
                    2'd2:    begin c = -r_x; s = -r_y; end
                    default: begin c = r_y;  s = -r_x; end
                endcase
                case (r_k)
                    2'd0:    begin r_s1 <= s; r_c1 <= c; end
                    2'd1:    begin r_s2 <= s; r_c2 <= c; end
                    default: begin r_sd <= s; r_cd <= c; end
                endcase
                r_k  <= r_k + 2'd1;
                r_op <= MOP_A;
            end
            ST_MUL: begin
                r_prod <= m_p;
            end
            ST_MACC: begin
                case (r_op)
                    MOP_A:  begin r_a   <= rq;         r_op <= MOP_B1; end
                    MOP_B1: begin r_b   <= rq;         r_op <= MOP_B2; end
                    MOP_B2: begin r_tmp <= rq;         r_op <= MOP_B3; end
                    MOP_B3: begin r_b   <= r_b - rq;   r_op <= MOP_D1; end
                    MOP_D1: begin r_den <= rq;         r_op <= MOP_D2; end
                    MOP_D2: begin r_tmp <= rq;         r_op <= MOP_D3; end
                    MOP_D3: begin
                        r_den <= r_den + rq;
                        r_x   <= abs_a;
                        r_y   <= r_b;
                        r_z   <= '0;
                        r_i   <= '0;
                        r_vec <= 1'b1;
                        r_job <= JOB_MAG;
                    end
                    MOP_NUM: r_num <= rq[DW-1] ? '0 : rq;
                    MOP_T: begin
                        r_t  <= r_prod[TW_T-1:0];
                        r_op <= MOP_HI;
                    end
                    MOP_HI: begin
                        r_seg <= r_prod[DW-1:0];
                        r_op  <= MOP_LO;
                    end
                    MOP_LO:  r_seg <= r_seg + rq;
                    default: r_op  <= MOP_A;
                endcase
            end
            ST_VEC1_END: begin
                r_op <= MOP_NUM;
            end
            ST_ATAN_SETUP: begin
                r_z   <= '0;
                r_i   <= '0;
                r_vec <= 1'b1;
                r_job <= JOB_ATAN;
                r_ang <= '0;
                r_op  <= MOP_T;
                if (r_den[DW-1]) begin
                    r_x   <= r_num;
                    r_y   <= -r_den;
                    r_off <= HALF_PI_Q;
                end else begin
                    r_x   <= r_den;
                    r_y   <= r_num;
                    r_off <= '0;
                end
            end
            ST_ATAN_END: begin
                r_ang <= ang_sum[DW-1] ? '0 : ang_sum;
                r_op  <= MOP_T;
            end
            ST_ACC: begin
                r_last_lat <= r_nlat;
                r_last_lon <= r_lon_in;
            end
            default: begin
            end
        endcase
    end

endmodule

// File: hdl/gco_checker.sv
module gco_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_in_ready,
    input logic         o_out_valid,
    input logic         i_out_ready,
    input logic [47:0]  o_total_distance_mm,
    input logic         o_fix_accepted,
    input logic         o_distance_added
);

    // A result holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before it was taken");

    // No new request is taken while a result is stuck.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("request taken while a result is pending");

    // A segment is only added for an accepted fix.
    a_added_implies_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_distance_added || o_fix_accepted))
        else $error("distance added for a rejected fix");

    // The odometer never runs backward.
    a_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> o_total_distance_mm >= $past(o_total_distance_mm))
        else $error("total distance decreased");

endmodule

bind gps_great_circle_odometer gco_checker u_gco_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_in_ready          (o_in_ready),
    .o_out_valid         (o_out_valid),
    .i_out_ready         (i_out_ready),
    .o_total_distance_mm (o_total_distance_mm),
    .o_fix_accepted      (o_fix_accepted),
    .o_distance_added    (o_distance_added)
);
